// File: hw/rtl/greedy_motif_search_top_defines.svh
// Assertion macros for the one RTL file that carries checks, the top level.
`ifndef GREEDY_MOTIF_SEARCH_TOP_DEFINES_SVH
`define GREEDY_MOTIF_SEARCH_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define GMS_ASSERT_IMPL(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define GMS_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define GMS_ASSERT_IMPL(label, prop)
`define GMS_NEVER(label, expr)
`endif
`endif

// File: hw/rtl/gms_pkg.sv
package gms_pkg;

    localparam int MAX_STRINGS = 16;
    localparam int MAX_LEN     = 256;
    localparam int MAX_MOTIF   = 8;
    localparam int STORE_SIZE  = MAX_STRINGS * MAX_LEN;
    localparam int ADDR_W      = $clog2(STORE_SIZE);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int POS_W       = $clog2(MAX_LEN);
    localparam int LEN_W       = POS_W + 1;
    localparam int STR_W       = $clog2(MAX_STRINGS);
    localparam int NUM_W       = STR_W + 1;
    localparam int COL_W       = $clog2(MAX_MOTIF);
    localparam int K_W         = COL_W + 1;
    localparam int SCORE_W     = 7;
    localparam int WEIGHT_W    = 33;

    localparam logic [1:0] REG_MOTIF_LEN   = 2'd0;
    localparam logic [1:0] REG_NUM_STRINGS = 2'd1;
    localparam logic [1:0] REG_STRING_LEN  = 2'd2;

    typedef struct packed {
        logic [1:0] base;
        logic       final_base;
    } in_item_t;

    typedef struct packed {
        logic [3:0] string_index;
        logic [7:0] motif_start;
        logic [6:0] best_score;
        logic       last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_counts;     // clear column counts
        logic acc_count;      // add base at (str, cur_start+col) to counts
        logic init_best;      // best_score <= score, best starts <= 0
        logic clr_score;
        logic acc_score;      // score += t - max(count column col)
        logic set_cur0;       // current_starts[0] <= pos
        logic clr_weight;     // weight <= 1
        logic mul_weight;     // weight *= count(col, base at str,pos+col)+1
        logic cand_done;      // compare weight against best for this string
        logic store_pick;     // current_starts[str] <= picked start
        logic commit_best;    // if score < best, copy starts
        logic zero_cur;       // current_starts[str] <= 0
        logic emit;
    } dp_cmd_t;

endpackage

// File: hw/rtl/gms_datapath.sv
module gms_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [1:0]             wr_base,
    input  logic [gms_pkg::ADDR_W-1:0] wr_addr,
    input  gms_pkg::dp_cmd_t       cmd,
    input  logic [gms_pkg::STR_W-1:0]  str,
    input  logic [gms_pkg::COL_W-1:0]  col,
    input  logic [gms_pkg::POS_W-1:0]  pos,
    input  logic                   use_pos,
    input  logic [gms_pkg::NUM_W-1:0]  eff_t,
    input  logic [gms_pkg::LEN_W-1:0]  eff_l,
    input  logic [gms_pkg::NUM_W-1:0]  num_t,
    output logic                   result_strobe,
    output gms_pkg::out_item_t     result
);
    import gms_pkg::*;

    logic [1:0] mem [STORE_SIZE];
    logic [1:0] rd_reg;
    logic [4:0] counts_reg [MAX_MOTIF*4];
    logic [POS_W-1:0] cur_reg [MAX_STRINGS];
    logic [POS_W-1:0] best_reg [MAX_STRINGS];
    logic [SCORE_W-1:0] score_reg, best_score_reg;
    logic [WEIGHT_W-1:0] weight_reg, best_w_reg;
    logic [POS_W-1:0] pick_reg;
    logic [COL_W-1:0] col_d_reg;
    logic [POS_W-1:0] pos_d_reg;
    dp_cmd_t cmd_d_reg;
    logic [ADDR_W:0] rd_addr;
    logic [POS_W:0] rd_pos;
    logic [4:0] col_max;
    logic [4:0] c0, c1, c2, c3, sel_cnt;
    logic cmp_ok;

    assign rd_pos = use_pos ? ({1'b0, pos} + {{(POS_W+1-COL_W){1'b0}}, col})
                            : ({1'b0, cur_reg[str]} + {{(POS_W+1-COL_W){1'b0}}, col});
    assign rd_addr = (ADDR_W+1)'(str) * (ADDR_W+1)'(eff_l) + (ADDR_W+1)'(rd_pos);

    // The memory read is registered; commands are delayed through a matching register.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_base;
        end
        rd_reg <= (rd_addr < STORE_SIZE) ? mem[rd_addr[ADDR_W-1:0]] : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_d_reg <= '0;
        end
        else
        begin
            cmd_d_reg <= cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        col_d_reg <= col;
        pos_d_reg <= pos;
    end

    assign c0 = counts_reg[{col, 2'd0}];
    assign c1 = counts_reg[{col, 2'd1}];
    assign c2 = counts_reg[{col, 2'd2}];
    assign c3 = counts_reg[{col, 2'd3}];
    always_comb
    begin
        col_max = c0;
        if (c1 > col_max) col_max = c1;
        if (c2 > col_max) col_max = c2;
        if (c3 > col_max) col_max = c3;
    end
    assign sel_cnt = counts_reg[{col_d_reg, rd_reg}];
    assign cmp_ok = score_reg < best_score_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clr_counts)
        begin
            for (int i = 0; i < MAX_MOTIF*4; i++) counts_reg[i] <= '0;
        end
        else if (cmd_d_reg.acc_count)
        begin
            counts_reg[{col_d_reg, rd_reg}] <= sel_cnt + 5'd1;
        end
        if (cmd.clr_score) score_reg <= '0;
        else if (cmd.acc_score) score_reg <= score_reg + SCORE_W'(eff_t - col_max);
        if (cmd.init_best)
        begin
            best_score_reg <= score_reg;
            for (int i = 0; i < MAX_STRINGS; i++) best_reg[i] <= '0;
        end
        else if (cmd.commit_best && cmp_ok)
        begin
            best_score_reg <= score_reg;
            for (int i = 0; i < MAX_STRINGS; i++) best_reg[i] <= cur_reg[i];
        end
        if (cmd.set_cur0) cur_reg[0] <= pos;
        if (cmd.zero_cur) cur_reg[str] <= '0;
        if (cmd.store_pick) cur_reg[str] <= pick_reg;
        if (cmd.clr_weight) weight_reg <= WEIGHT_W'(1);
        else if (cmd_d_reg.mul_weight)
            weight_reg <= WEIGHT_W'(weight_reg * ({1'b0, sel_cnt} + 6'd1));
        if (cmd_d_reg.cand_done && (pos_d_reg == '0 || weight_reg > best_w_reg))
        begin
            best_w_reg <= weight_reg;
            pick_reg <= pos_d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_strobe <= 1'b0;
        end
        else
        begin
            result_strobe <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result.string_index <= 4'(str);
            result.motif_start  <= 8'(best_reg[str]);
            result.best_score   <= best_score_reg;
            result.last         <= ({1'b0, str} + NUM_W'(1)) == num_t;
        end
    end
endmodule

// File: hw/rtl/gms_ctrl.sv
module gms_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [gms_pkg::K_W-1:0]    eff_k,
    input  logic [gms_pkg::NUM_W-1:0]  eff_t,
    input  logic [gms_pkg::LEN_W-1:0]  eff_l,
    output logic                       busy,
    output gms_pkg::dp_cmd_t           cmd,
    output logic [gms_pkg::STR_W-1:0]  str,
    output logic [gms_pkg::COL_W-1:0]  col,
    output logic [gms_pkg::POS_W-1:0]  pos,
    output logic                       use_pos
);
    import gms_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_ICNT   = 10'b0000000010,
        S_ISCORE = 10'b0000000100,
        S_POS    = 10'b0000001000,
        S_CNT    = 10'b0000010000,
        S_CAND   = 10'b0000100000,
        S_PICK   = 10'b0001000000,
        S_SCNT   = 10'b0010000000,
        S_SCORE  = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [STR_W:0] s_reg, s_next;     // string loop
    logic [STR_W:0] i_reg, i_next;     // string being picked
    logic [K_W-1:0] c_reg, c_next;
    logic [LEN_W-1:0] p_reg, p_next;   // candidate start in string i
    logic [LEN_W-1:0] q_reg, q_next;   // start in string 0
    logic [2:0] w_reg, w_next;         // drain for delayed datapath steps
    logic col_last;

    assign col_last = (c_reg + K_W'(1)) == eff_k;
    assign busy = state_reg != S_IDLE;
    assign col = c_reg[COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            s_reg <= '0; i_reg <= '0; c_reg <= '0;
            p_reg <= '0; q_reg <= '0; w_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s_reg <= s_next; i_reg <= i_next; c_reg <= c_next;
            p_reg <= p_next; q_reg <= q_next; w_reg <= w_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_next = s_reg; i_next = i_reg; c_next = c_reg;
        p_next = p_reg; q_next = q_reg; w_next = w_reg;
        cmd = '0;
        use_pos = 1'b0;
        pos = p_reg[POS_W-1:0];
        str = s_reg[STR_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    cmd.clr_counts = 1'b1;
                    cmd.zero_cur = 1'b1;
                    s_next = '0; c_next = '0;
                    state_next = S_ICNT;
                end
            end
            // Zero all current starts and count every string at start 0.
            S_ICNT:
            begin
                use_pos = 1'b1;
                pos = '0;
                cmd.zero_cur = 1'b1;
                cmd.acc_count = 1'b1;
                c_next = c_reg + K_W'(1);
                if (col_last)
                begin
                    c_next = '0;
                    s_next = s_reg + 1'b1;
                    if (s_next == (STR_W+1)'(eff_t))
                    begin
                        w_next = 3'd2;
                        cmd.clr_score = 1'b1;
                        state_next = S_ISCORE;
                    end
                end
            end
            S_ISCORE:
            begin
                if (w_reg != '0)
                begin
                    w_next = w_reg - 3'd1;
                    cmd.clr_score = 1'b1;
                end
                else
                begin
                    cmd.acc_score = 1'b1;
                    c_next = c_reg + K_W'(1);
                    if (col_last)
                    begin
                        c_next = '0;
                        q_next = '0;
                        w_next = 3'd1;
                        state_next = S_POS;
                    end
                end
            end
            S_POS:
            begin
                if (w_reg != '0)
                begin
                    // score settles; seed best
                    w_next = '0;
                    cmd.init_best = 1'b1;
                end
                else if ((q_reg + LEN_W'(eff_k)) > eff_l)
                begin
                    s_next = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    pos = q_reg[POS_W-1:0];
                    cmd.set_cur0 = 1'b1;
                    cmd.clr_counts = 1'b1;
                    i_next = (STR_W+1)'(1);
                    s_next = '0; c_next = '0;
                    state_next = S_CNT;
                end
            end
            // Count strings 0..i-1 from their current starts.
            S_CNT:
            begin
                if (s_reg == i_reg)
                begin
                    if (w_reg != 3'd2)
                    begin
                        w_next = w_reg + 3'd1;
                    end
                    else
                    begin
                        w_next = '0;
                        p_next = '0; c_next = '0;
                        cmd.clr_weight = 1'b1;
                        state_next = S_CAND;
                    end
                end
                else
                begin
                    cmd.acc_count = 1'b1;
                    c_next = c_reg + K_W'(1);
                    if (col_last)
                    begin
                        c_next = '0;
                        s_next = s_reg + 1'b1;
                    end
                end
            end
            // One column per cycle, with drain steps after each candidate: weight *= count+1 over string i at p.
            S_CAND:
            begin
                use_pos = 1'b1;
                s_next = s_reg;
                if ((p_reg + LEN_W'(eff_k)) > eff_l)
                begin
                    if (w_reg != 3'd2)
                    begin
                        w_next = w_reg + 3'd1;
                    end
                    else
                    begin
                        w_next = '0;
                        cmd.store_pick = 1'b1;
                        state_next = S_PICK;
                    end
                end
                else if (c_reg == eff_k)
                begin
                    // weight of this candidate is complete after the delay
                    if (w_reg != 3'd1)
                    begin
                        w_next = w_reg + 3'd1;
                    end
                    else
                    begin
                        w_next = '0;
                        cmd.cand_done = 1'b1;
                        p_next = p_reg + LEN_W'(1);
                        c_next = '0;
                    end
                end
                else
                begin
                    cmd.mul_weight = 1'b1;
                    c_next = c_reg + K_W'(1);
                end
                if (c_reg == '0 && w_reg == '0 && !cmd.store_pick)
                begin
                    cmd.clr_weight = cmd.clr_weight | (c_reg == '0);
                    cmd.mul_weight = (p_reg + LEN_W'(eff_k)) <= eff_l;
                end
            end
            S_PICK:
            begin
                i_next = i_reg + 1'b1;
                cmd.clr_counts = 1'b1;
                s_next = '0; c_next = '0;
                if (i_next == (STR_W+1)'(eff_t))
                begin
                    state_next = S_SCNT;
                end
                else
                begin
                    state_next = S_CNT;
                end
            end
            S_SCNT:
            begin
                if (s_reg == i_reg)
                begin
                    if (w_reg != 3'd2)
                    begin
                        w_next = w_reg + 3'd1;
                        cmd.clr_score = 1'b1;
                    end
                    else
                    begin
                        w_next = '0;
                        c_next = '0;
                        state_next = S_SCORE;
                    end
                end
                else
                begin
                    cmd.acc_count = 1'b1;
                    c_next = c_reg + K_W'(1);
                    if (col_last)
                    begin
                        c_next = '0;
                        s_next = s_reg + 1'b1;
                    end
                end
            end
            S_SCORE:
            begin
                if (c_reg == eff_k)
                begin
                    cmd.commit_best = 1'b1;
                    q_next = q_reg + LEN_W'(1);
                    c_next = '0;
                    state_next = S_POS;
                end
                else
                begin
                    cmd.acc_score = 1'b1;
                    c_next = c_reg + K_W'(1);
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                s_next = s_reg + 1'b1;
                if (s_next == (STR_W+1)'(eff_t))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_CAND)
        begin
            str = i_reg[STR_W-1:0];
        end
    end
endmodule

// File: hw/rtl/greedy_motif_search_top.sv
// Results: after the final base is taken and the search completes, the t results
//   follow one per cycle.
// Throughput: one base per cycle while loading; start is refused while busy.
// rst_n clears control state asynchronously; the base store is not cleared.
`include "greedy_motif_search_top_defines.svh"
module greedy_motif_search_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  gms_pkg::in_item_t  request,
    output logic               result_valid,
    output gms_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);
    import gms_pkg::*;

    logic [3:0] motif_len_reg;
    logic [4:0] num_strings_reg;
    logic [8:0] string_len_reg;
    logic [CNT_W-1:0] load_reg;
    logic [K_W-1:0] eff_k;
    logic [NUM_W-1:0] eff_t;
    logic [LEN_W-1:0] eff_l;
    logic [K_W-1:0] k_sat;
    logic accept, ctl_busy;
    dp_cmd_t cmd;
    logic [STR_W-1:0] str;
    logic [COL_W-1:0] col;
    logic [POS_W-1:0] pos;
    logic use_pos;

    assign cfg_ready = 1'b1;
    assign busy = ctl_busy;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motif_len_reg <= 4'd8;
            num_strings_reg <= 5'd16;
            string_len_reg <= 9'd256;
            load_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MOTIF_LEN:   motif_len_reg <= cfg_data[3:0];
                    REG_NUM_STRINGS: num_strings_reg <= cfg_data[4:0];
                    REG_STRING_LEN:  string_len_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                if (request.final_base) load_reg <= '0;
                else if (load_reg < STORE_SIZE) load_reg <= load_reg + 1'b1;
            end
        end
    end

    assign eff_l = (string_len_reg == 9'd0) ? LEN_W'(1) :
                   (string_len_reg > MAX_LEN) ? LEN_W'(MAX_LEN) : LEN_W'(string_len_reg);
    assign eff_t = (num_strings_reg < 5'd2) ? NUM_W'(2) :
                   (num_strings_reg > MAX_STRINGS) ? NUM_W'(MAX_STRINGS)
                                                   : NUM_W'(num_strings_reg);
    assign k_sat = (motif_len_reg == 4'd0) ? K_W'(1) :
                   (motif_len_reg > MAX_MOTIF) ? K_W'(MAX_MOTIF) : K_W'(motif_len_reg);
    assign eff_k = (LEN_W'(k_sat) > eff_l) ? K_W'(eff_l) : k_sat;

    gms_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .go(accept && request.final_base),
        .eff_k(eff_k), .eff_t(eff_t), .eff_l(eff_l),
        .busy(ctl_busy), .cmd(cmd), .str(str), .col(col), .pos(pos),
        .use_pos(use_pos)
    );

    gms_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .wr_en(accept && load_reg < STORE_SIZE),
        .wr_base(request.base),
        .wr_addr(load_reg[ADDR_W-1:0]),
        .cmd(cmd), .str(str), .col(col), .pos(pos), .use_pos(use_pos),
        .eff_t(eff_t), .eff_l(eff_l), .num_t(eff_t),
        .result_strobe(result_valid), .result(result)
    );

    `GMS_NEVER(a_no_start_when_busy_load, busy && result_valid && cmd.clr_counts)
    `GMS_ASSERT_IMPL(a_emit_busy, cmd.emit |-> busy)
    `GMS_ASSERT_IMPL(a_last_ends, (result_valid && result.last) |=> !result_valid)
endmodule

// File: bench/tb_greedy_motif_search_top.sv
`timescale 1ns / 100ps

module tb_greedy_motif_search_top;
    import gms_pkg::*;

    localparam int PERIOD = 12;

    typedef struct {
        int k;
        int t;
        int l;
        int n;
        int fill;    // -1 random, 0..3 one base throughout, 4 alternating A and T
        int score;   // -1 when the predictor supplies the results
    } plan_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_item_t   request;
    logic       result_valid;
    out_item_t  result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    logic [1:0] dna_store [0:STORE_SIZE-1];
    int         fill_cnt;
    int         high_water;
    int         reg_k;
    int         reg_t;
    int         reg_l;
    int         eff_k;
    int         eff_t;
    int         eff_l;
    int         col_cnt [0:MAX_MOTIF*4-1];
    int         cur_start [0:MAX_STRINGS-1];
    int         best_start [0:MAX_STRINGS-1];
    int         hand_score;
    int         idle_pct;
    int         mismatch_count;
    out_item_t  pending_motifs [$];
    out_item_t  want;

    greedy_motif_search_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic void clamp_dims();
        eff_l = reg_l < 1 ? 1 : (reg_l > MAX_LEN ? MAX_LEN : reg_l);
        eff_t = reg_t < 2 ? 2 : (reg_t > MAX_STRINGS ? MAX_STRINGS : reg_t);
        eff_k = reg_k < 1 ? 1 : (reg_k > MAX_MOTIF ? MAX_MOTIF : reg_k);
        if (eff_k > eff_l)
            eff_k = eff_l;
    endfunction

    function automatic int base_of(int s, int p);
        int addr;
        addr = s * eff_l + p;
        if (addr >= STORE_SIZE)
            return 0;
        return int'(dna_store[addr]);
    endfunction

    function automatic void tally_columns(int n);
        for (int i = 0; i < MAX_MOTIF * 4; i++)
            col_cnt[i] = 0;
        for (int s = 0; s < n; s++)
            for (int c = 0; c < eff_k; c++)
                col_cnt[c * 4 + base_of(s, cur_start[s] + c)]++;
    endfunction

    function automatic int consensus_mismatch();
        int total;
        int top;
        total = 0;
        tally_columns(eff_t);
        for (int c = 0; c < eff_k; c++)
        begin
            top = 0;
            for (int b = 0; b < 4; b++)
                if (col_cnt[c * 4 + b] > top)
                    top = col_cnt[c * 4 + b];
            total += eff_t - top;
        end
        return total;
    endfunction

    function automatic int most_probable_start(int s);
        longint unsigned w;
        longint unsigned top_w;
        int pick;
        pick  = 0;
        top_w = 0;
        tally_columns(s);
        for (int p = 0; p + eff_k <= eff_l; p++)
        begin
            w = 1;
            for (int c = 0; c < eff_k; c++)
                w = w * longint'(col_cnt[c * 4 + base_of(s, p + c)] + 1);
            if (p == 0 || w > top_w)
            begin
                top_w = w;
                pick  = p;
            end
        end
        return pick;
    endfunction

    function automatic void search_motifs();
        int best_total;
        int sc;
        out_item_t item;
        clamp_dims();
        for (int i = 0; i < eff_t; i++)
        begin
            cur_start[i]  = 0;
            best_start[i] = 0;
        end
        best_total = consensus_mismatch();
        for (int pos = 0; pos + eff_k <= eff_l; pos++)
        begin
            cur_start[0] = pos;
            for (int i = 1; i < eff_t; i++)
                cur_start[i] = most_probable_start(i);
            sc = consensus_mismatch();
            if (sc < best_total)
            begin
                best_total = sc;
                for (int i = 0; i < eff_t; i++)
                    best_start[i] = cur_start[i];
            end
        end
        for (int i = 0; i < eff_t; i++)
        begin
            item.string_index = i[3:0];
            item.motif_start  = hand_score >= 0 ? 8'd0 : best_start[i][7:0];
            item.best_score   = hand_score >= 0 ? hand_score[6:0] : best_total[6:0];
            item.last         = (i + 1 == eff_t);
            pending_motifs = {pending_motifs, item};
        end
    endfunction

    function automatic void load_base(logic [1:0] b, logic f);
        if (fill_cnt < STORE_SIZE)
        begin
            dna_store[fill_cnt] = b;
            fill_cnt++;
        end
        if (fill_cnt > high_water)
            high_water = fill_cnt;
        if (f)
        begin
            fill_cnt = 0;
            search_motifs();
        end
    endfunction

    // ---------------- driving ----------------

    task automatic send_base(logic [1:0] b, logic f);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start              <= 1'b1;
        request.base       <= b;
        request.final_base <= f;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        load_base(b, f);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        wait (pending_motifs.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[8:0];
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            REG_MOTIF_LEN:   reg_k = v & 'hF;
            REG_NUM_STRINGS: reg_t = v & 'h1F;
            default:         reg_l = v & 'h1FF;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int k, int t, int l);
        drain();
        write_reg(REG_MOTIF_LEN, k);
        write_reg(REG_NUM_STRINGS, t);
        write_reg(REG_STRING_LEN, l);
    endtask

    task automatic send_set(int n, int fill);
        logic [1:0] b;
        for (int i = 0; i < n; i++)
        begin
            if (fill < 0)
                b = 2'($urandom_range(3));
            else if (fill == 4)
                b = i[0] ? 2'd3 : 2'd0;
            else
                b = fill[1:0];
            send_base(b, i == n - 1);
        end
    endtask

    // ---------------- checking ----------------

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_motifs.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %p", $time, result);
                mismatch_count++;
            end
            else
            begin
                want = pending_motifs.pop_front();
                if (result.string_index !== want.string_index
                    || result.motif_start !== want.motif_start
                    || result.best_score !== want.best_score
                    || result.last !== want.last)
                begin
                    $display("%0t mismatch: expected %p, actual %p", $time, want, result);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    plan_row_t plan [4] = '{
        '{0, 0, 0, 2, 4, 1},     // every register below range: k=1, t=2, L=1
        '{3, 2, 4, 8, 3, 0},     // all T, perfect consensus
        '{8, 2, 3, 6, -1, -1},   // motif longer than the strings
        '{8, 2, 3, 3, -1, -1}    // early final base over a store already written
    };

    int rand_sent;
    int need;
    int n;
    int r;
    int k;
    int t;
    int l;

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_MOTIF_LEN;
        cfg_data       = '0;
        fill_cnt       = 0;
        high_water     = 0;
        reg_k          = 8;
        reg_t          = 16;
        reg_l          = 256;
        hand_score     = -1;
        idle_pct       = 0;
        mismatch_count = 0;
        for (int i = 0; i < STORE_SIZE; i++)
            dna_store[i] = 2'd0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            configure(plan[i].k, plan[i].t, plan[i].l);
            hand_score = plan[i].score;
            send_set(plan[i].n, plan[i].fill);
        end
        drain();
        hand_score = -1;

        rand_sent = 0;
        while (rand_sent < 220)
        begin
            case (rand_sent * 4 / 220)
                0: idle_pct = 0;
                1: idle_pct = 63;
                2: idle_pct = 0;
                default: idle_pct = 22;
            endcase
            if ($urandom_range(2) == 0)
            begin
                k = $urandom_range(1, 4);
                t = $urandom_range(2, 4);
                l = $urandom_range(k, 12);
                r = $urandom_range(9);
                if (r == 0)
                    k = 0;
                else if (r == 1)
                    t = 1;
                configure(k, t, l);
            end
            clamp_dims();
            need = eff_t * eff_l;
            r = $urandom_range(9);
            if (r == 0 && need > 1 && high_water >= need)
                n = $urandom_range(1, need - 1);
            else if (r == 1)
                n = need + $urandom_range(1, 5);
            else
                n = need;
            send_set(n, -1);
            rand_sent += n;
        end

        // Largest motif and string count: full motif over sixteen strings.
        idle_pct = 22;
        configure(15, 31, 8);
        send_set(128, -1);

        drain();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && pending_motifs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
